FILE: hdl/asbox_pkg.sv
// Shared types and constants for the computed AES forward S-box.
// Holds the sequencer state type, the field constants and the affine transform.
// No dependencies.
`default_nettype none

package asbox_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_FINISH
  } state_t;

  localparam logic [7:0] FIELD_POLY_LOW = 8'h1b;
  localparam logic [7:0] AFFINE_CONST   = 8'h63;
  localparam logic [7:0] GF_ONE         = 8'h01;

  // Exponent 254 is the sum of 2^1 .. 2^7, so seven square-then-multiply rounds.
  localparam int unsigned ROUNDS = 7;
  localparam logic [2:0]  LAST_ROUND = 3'(ROUNDS - 1);

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int unsigned k);
    rotl8 = (x << k) | (x >> (8 - k));
  endfunction

  function automatic logic [7:0] affine_fwd(input logic [7:0] x);
    affine_fwd = x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4)
                 ^ AFFINE_CONST;
  endfunction

  typedef struct packed {
    logic [7:0] op_a;
    logic [7:0] op_b;
  } mul_req_t;

endpackage

`default_nettype wire

FILE: hdl/asbox_gfmul.sv
// GF(2^8) multiplier modulo x^8+x^4+x^3+x+1, shared by every step of the sequencer.
// Depends on asbox_pkg for the operand struct and the reduction constant.
`default_nettype none

module asbox_gfmul (
  input  wire asbox_pkg::mul_req_t req,
  output logic [7:0]               product
);

  always_comb begin
    logic [7:0] a;
    logic [7:0] p;
    a = req.op_a;
    p = 8'h00;
    // Shift-and-add with reduction folded into every doubling of the multiplicand.
    for (int i = 0; i < 8; i++) begin
      if (req.op_b[i]) begin
        p = p ^ a;
      end
      a = a[7] ? ((a << 1) ^ asbox_pkg::FIELD_POLY_LOW) : (a << 1);
    end
    product = p;
  end

endmodule

`default_nettype wire

FILE: hdl/aes_forward_sbox_compute.sv
// Top level of the computed AES forward S-box: sequencer, operand registers, output register.
// Depends on asbox_pkg and asbox_gfmul.
//
//   channel | direction | tdata fields (low bit up) | handshake
//   s_axis  | in        | in_byte[7:0]              | tvalid/tready
//   m_axis  | out       | sub_byte[7:0]             | tvalid/tready
//
// The inverse is formed as x^254 with one GF(2^8) multiplier, squaring and multiplying
// in turn for seven rounds. The finish state loads the affine result into the output
// register once that register is free, and the sequencer then returns to idle.
// A new item is taken only when the sequencer is idle; the finished value waits in the
// output register while the next item is already at work.
// Reset (rst, synchronous) empties the sequencer and the output register.
`default_nettype none

module aes_forward_sbox_compute (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // in_byte[7:0]
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // sub_byte[7:0]
);

  asbox_pkg::state_t   state, state_next;
  logic [2:0]          round;
  logic [7:0]          sq;
  logic [7:0]          acc;
  asbox_pkg::mul_req_t req;
  logic [7:0]          product;
  logic                out_free;
  logic                load_out;

  asbox_gfmul u_mul (
    .req     (req),
    .product (product)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      asbox_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = asbox_pkg::ST_SQR;
        end
      end
      asbox_pkg::ST_SQR: begin
        state_next = asbox_pkg::ST_MUL;
      end
      asbox_pkg::ST_MUL: begin
        state_next = (round == asbox_pkg::LAST_ROUND) ? asbox_pkg::ST_FINISH
                                                     : asbox_pkg::ST_SQR;
      end
      asbox_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = asbox_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = asbox_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    req.op_a      = sq;
    req.op_b      = sq;
    case (state)
      asbox_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      asbox_pkg::ST_SQR: begin
        req.op_a = sq;
        req.op_b = sq;
      end
      asbox_pkg::ST_MUL: begin
        req.op_a = acc;
        req.op_b = sq;
      end
      asbox_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= asbox_pkg::ST_IDLE;
      round         <= 3'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == asbox_pkg::ST_IDLE) begin
        round <= 3'd0;
      end else if (state == asbox_pkg::ST_MUL) begin
        round <= round + 3'd1;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sq  <= s_axis_tdata;
      acc <= asbox_pkg::GF_ONE;
    end else if (state == asbox_pkg::ST_SQR) begin
      sq <= product;
    end else if (state == asbox_pkg::ST_MUL) begin
      acc <= product;
    end
    if (load_out) begin
      m_axis_tdata <= asbox_pkg::affine_fwd(acc);
    end
  end

endmodule

`default_nettype wire
